// ----- rtl/core/mah_pkg.sv -----
`timescale 1ns / 1ps
package mah_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int PERCENT_W  = 7;
    localparam int BAR_W      = 4;
    localparam int WINDOW_DEF = 15;

    localparam int FULL_SCALE = 1023;
    localparam int PCT_SPAN   = 100;
    localparam int BAR_SPAN   = 10;

    // Exact floor(n / FULL_SCALE) as (n * FS_RECIP) >> FS_SHIFT for n below 2**17
    localparam int          FS_SHIFT  = 38;
    localparam logic [63:0] FS_RECIP  = ((64'd1 << FS_SHIFT) + 64'(FULL_SCALE) - 64'd1)
                                        / 64'(FULL_SCALE);
    localparam int          SCALE_W   = 36;
    localparam logic [63:0] PCT_MUL   = FS_RECIP * 64'(PCT_SPAN);
    localparam logic [63:0] BAR_MUL   = FS_RECIP * 64'(BAR_SPAN);

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LOW_ON   = 3'd0,
        REG_LOW_OFF  = 3'd1,
        REG_MID_ON   = 3'd2,
        REG_MID_OFF  = 3'd3,
        REG_HIGH_ON  = 3'd4,
        REG_HIGH_OFF = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] on_level;
        logic [SAMPLE_W-1:0] off_level;
    } thr_t;

    localparam logic [SAMPLE_W-1:0] LOW_ON_RST   = 10'd150;
    localparam logic [SAMPLE_W-1:0] LOW_OFF_RST  = 10'd120;
    localparam logic [SAMPLE_W-1:0] MID_ON_RST   = 10'd350;
    localparam logic [SAMPLE_W-1:0] MID_OFF_RST  = 10'd300;
    localparam logic [SAMPLE_W-1:0] HIGH_ON_RST  = 10'd550;
    localparam logic [SAMPLE_W-1:0] HIGH_OFF_RST = 10'd500;

endpackage

// ----- rtl/core/moving_average_level_hysteresis.sv -----
`timescale 1ns / 1ps
// Pipeline: an accepted word passes through registered stages in order (running sum,
// then the divide by the window, then scaling and hysteresis) to the result word.
// Throughput: one word per cycle while out_stall is low; each stage advances when the next is empty or moving.
// Reset (rst_n low, asynchronous): sample cells, running sum, flags and pipeline
// valids clear to zero; thresholds return to 150/120, 350/300, 550/500.
module moving_average_level_hysteresis #(
    parameter int WINDOW = mah_pkg::WINDOW_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mah_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mah_pkg::SAMPLE_W-1:0]    smoothed,
    output logic [mah_pkg::PERCENT_W-1:0]   percent,
    output logic [mah_pkg::BAR_W-1:0]       bar_level,
    output logic                            low_lit,
    output logic                            mid_lit,
    output logic                            high_lit,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mah_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mah_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mah_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import mah_pkg::*;

    localparam int SUM_W   = $clog2(WINDOW * FULL_SCALE + 1);
    localparam int DIV_K   = SUM_W + 2 * $clog2(WINDOW + 1) + 1;
    localparam logic [63:0] DIV_M = ((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1)
                                    / 64'(WINDOW);
    localparam int PROD_W  = SUM_W + DIV_K + 1;
    localparam int SPROD_W = SAMPLE_W + SCALE_W;

    // configuration
    thr_t low_thr_reg, mid_thr_reg, high_thr_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= '{on_level: LOW_ON_RST,  off_level: LOW_OFF_RST};
            mid_thr_reg  <= '{on_level: MID_ON_RST,  off_level: MID_OFF_RST};
            high_thr_reg <= '{on_level: HIGH_ON_RST, off_level: HIGH_OFF_RST};
        end
        else if (cfg_wr)
        begin
            case (cfg_idx_t'(paddr[4:2]))
                REG_LOW_ON:   low_thr_reg.on_level   <= pwdata[SAMPLE_W-1:0];
                REG_LOW_OFF:  low_thr_reg.off_level  <= pwdata[SAMPLE_W-1:0];
                REG_MID_ON:   mid_thr_reg.on_level   <= pwdata[SAMPLE_W-1:0];
                REG_MID_OFF:  mid_thr_reg.off_level  <= pwdata[SAMPLE_W-1:0];
                REG_HIGH_ON:  high_thr_reg.on_level  <= pwdata[SAMPLE_W-1:0];
                REG_HIGH_OFF: high_thr_reg.off_level <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx_t'(paddr[4:2]))
            REG_LOW_ON:   prdata = CFG_DATA_W'(low_thr_reg.on_level);
            REG_LOW_OFF:  prdata = CFG_DATA_W'(low_thr_reg.off_level);
            REG_MID_ON:   prdata = CFG_DATA_W'(mid_thr_reg.on_level);
            REG_MID_OFF:  prdata = CFG_DATA_W'(mid_thr_reg.off_level);
            REG_HIGH_ON:  prdata = CFG_DATA_W'(high_thr_reg.on_level);
            REG_HIGH_OFF: prdata = CFG_DATA_W'(high_thr_reg.off_level);
            default:      prdata = '0;
        endcase
    end

    // pipeline control: a stage advances when the one after it is empty or moving
    logic sum_vld_reg, avg_vld_reg, out_vld_reg;
    logic en_sum, en_avg, en_out, accept;

    assign en_out   = !out_vld_reg || !out_stall;
    assign en_avg   = !avg_vld_reg || en_out;
    assign en_sum   = !sum_vld_reg || en_avg;
    assign in_stall = !en_sum;
    assign accept   = in_valid && en_sum;

    // sample chain: the last cell holds the oldest word in the window
    logic [SAMPLE_W-1:0] tap [WINDOW];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                mah_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .d     (sample),
                    .q     (tap[gi])
                );
            end
            else
            begin : g_body
                mah_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (accept),
                    .d     (tap[gi-1]),
                    .q     (tap[gi])
                );
            end
        end
    endgenerate

    // stage 1: running sum
    logic [SUM_W-1:0] sum_reg, sum_next;

    assign sum_next = sum_reg - SUM_W'(tap[WINDOW-1]) + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sum_reg <= sum_next;
            end
            if (en_sum)
            begin
                sum_vld_reg <= in_valid;
            end
        end
    end

    // stage 2: divide by the window with a reciprocal multiply
    logic [PROD_W-1:0]   div_prod;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;

    assign div_prod = {{(DIV_K+1){1'b0}}, sum_reg} * {{SUM_W{1'b0}}, DIV_M[DIV_K:0]};
    assign avg_next = div_prod[DIV_K +: SAMPLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_vld_reg <= 1'b0;
        end
        else if (en_avg)
        begin
            avg_vld_reg <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_avg && sum_vld_reg)
        begin
            avg_reg <= avg_next;
        end
    end

    // stage 3: scale to percent and bar, update the indicator flags
    logic [SPROD_W-1:0]   pct_prod, bar_prod;
    logic [SAMPLE_W-1:0]  smoothed_reg;
    logic [PERCENT_W-1:0] percent_reg;
    logic [BAR_W-1:0]     bar_reg;
    logic low_reg, mid_reg, high_reg;
    logic low_next, mid_next, high_next;

    assign pct_prod = {{SCALE_W{1'b0}}, avg_reg} * {{SAMPLE_W{1'b0}}, PCT_MUL[SCALE_W-1:0]};
    assign bar_prod = {{SCALE_W{1'b0}}, avg_reg} * {{SAMPLE_W{1'b0}}, BAR_MUL[SCALE_W-1:0]};

    mah_level u_low (
        .level    (avg_reg),
        .thr      (low_thr_reg),
        .flag_in  (low_reg),
        .flag_out (low_next)
    );

    mah_level u_mid (
        .level    (avg_reg),
        .thr      (mid_thr_reg),
        .flag_in  (mid_reg),
        .flag_out (mid_next)
    );

    mah_level u_high (
        .level    (avg_reg),
        .thr      (high_thr_reg),
        .flag_in  (high_reg),
        .flag_out (high_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            low_reg     <= 1'b0;
            mid_reg     <= 1'b0;
            high_reg    <= 1'b0;
        end
        else if (en_out)
        begin
            out_vld_reg <= avg_vld_reg;
            // flags advance only on a real word
            if (avg_vld_reg)
            begin
                low_reg  <= low_next;
                mid_reg  <= mid_next;
                high_reg <= high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && avg_vld_reg)
        begin
            smoothed_reg <= avg_reg;
            percent_reg  <= pct_prod[FS_SHIFT +: PERCENT_W];
            bar_reg      <= bar_prod[FS_SHIFT +: BAR_W];
        end
    end

    assign out_valid = out_vld_reg;
    assign smoothed  = smoothed_reg;
    assign percent   = percent_reg;
    assign bar_level = bar_reg;
    assign low_lit   = low_reg;
    assign mid_lit   = mid_reg;
    assign high_lit  = high_reg;

endmodule

// ----- rtl/core/mah_cell.sv -----
`timescale 1ns / 1ps
module mah_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic [mah_pkg::SAMPLE_W-1:0]  d,
    output logic [mah_pkg::SAMPLE_W-1:0]  q
);
    import mah_pkg::*;

    logic [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// ----- rtl/core/mah_level.sv -----
`timescale 1ns / 1ps
module mah_level (
    input  logic [mah_pkg::SAMPLE_W-1:0] level,
    input  mah_pkg::thr_t                thr,
    input  logic                         flag_in,
    output logic                         flag_out
);
    import mah_pkg::*;

    logic turned_on;

    // turn on first, then test the off threshold on the same level
    assign turned_on = flag_in || (level >= thr.on_level);
    assign flag_out  = turned_on && !(level < thr.off_level);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import mah_pkg::*;

    localparam int REG_COUNT     = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_SAMPLES = 230;
    localparam logic [2:0] SPARE_IDX_LO = 3'd6;
    localparam logic [2:0] SPARE_IDX_HI = 3'd7;

    typedef enum int {LOW_IND, MID_IND, HIGH_IND} indicator_t;
    typedef enum int {PAIR_ORDERED, PAIR_CROSSED, PAIR_ANY} pair_style_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  smoothed;
        logic [PERCENT_W-1:0] percent;
        logic [BAR_W-1:0]     bar_level;
        logic                 low_lit;
        logic                 mid_lit;
        logic                 high_lit;
    } level_word_t;

    class level_board;
        bit [SAMPLE_W-1:0] window_ring [WINDOW_DEF];
        int                next_slot;
        bit [13:0]         running_sum;
        bit                lit [3];
        bit [SAMPLE_W-1:0] on_at [3]     = '{LOW_ON_RST, MID_ON_RST, HIGH_ON_RST};
        bit [SAMPLE_W-1:0] off_below [3] = '{LOW_OFF_RST, MID_OFF_RST, HIGH_OFF_RST};
        level_word_t       due_words [$];
        int                errors;

        function void set_threshold(logic [2:0] idx, logic [31:0] data);
            bit [SAMPLE_W-1:0] v;
            v = data[SAMPLE_W-1:0];
            case (idx)
                REG_LOW_ON:   on_at[LOW_IND] = v;
                REG_LOW_OFF:  off_below[LOW_IND] = v;
                REG_MID_ON:   on_at[MID_IND] = v;
                REG_MID_OFF:  off_below[MID_IND] = v;
                REG_HIGH_ON:  on_at[HIGH_IND] = v;
                REG_HIGH_OFF: off_below[HIGH_IND] = v;
                default: ;
            endcase
        endfunction

        function void take_sample(bit [SAMPLE_W-1:0] s);
            level_word_t w;
            int avg;
            // replace the oldest sample in the window
            running_sum = running_sum - window_ring[next_slot] + s;
            window_ring[next_slot] = s;
            next_slot = (next_slot == WINDOW_DEF - 1) ? 0 : next_slot + 1;
            avg = running_sum / WINDOW_DEF;
            // turn on first, then off, against the same average
            for (int k = 0; k < 3; k++)
            begin
                if (!lit[k] && avg >= on_at[k])
                    lit[k] = 1'b1;
                if (lit[k] && avg < off_below[k])
                    lit[k] = 1'b0;
            end
            w.smoothed  = SAMPLE_W'(avg);
            w.percent   = PERCENT_W'(avg * PCT_SPAN / FULL_SCALE);
            w.bar_level = BAR_W'(avg * BAR_SPAN / FULL_SCALE);
            w.low_lit   = lit[LOW_IND];
            w.mid_lit   = lit[MID_IND];
            w.high_lit  = lit[HIGH_IND];
            due_words.push_back(w);
        endfunction

        function void note_field(string tag, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, tag, want_v, got_v);
                errors++;
            end
        endfunction

        function void match_word(level_word_t got);
            level_word_t want;
            if (due_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected, actual smoothed %0d",
                         $time, got.smoothed);
                errors++;
                return;
            end
            want = due_words.pop_front();
            note_field("smoothed", 32'(want.smoothed), 32'(got.smoothed));
            note_field("percent", 32'(want.percent), 32'(got.percent));
            note_field("bar_level", 32'(want.bar_level), 32'(got.bar_level));
            note_field("low_lit", 32'(want.low_lit), 32'(got.low_lit));
            note_field("mid_lit", 32'(want.mid_lit), 32'(got.mid_lit));
            note_field("high_lit", 32'(want.high_lit), 32'(got.high_lit));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   smoothed;
    logic [PERCENT_W-1:0]  percent;
    logic [BAR_W-1:0]      bar_level;
    logic                  low_lit;
    logic                  mid_lit;
    logic                  high_lit;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    level_board        board;
    int                send_idle_pct = 30;
    int                stall_pct = 54;
    int                quiet_cycles = 0;
    int                target_level = 0;
    int                run_left = 0;
    logic [SAMPLE_W-1:0] levels [REG_COUNT];

    moving_average_level_hysteresis u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .smoothed  (smoothed),
        .percent   (percent),
        .bar_level (bar_level),
        .low_lit   (low_lit),
        .mid_lit   (mid_lit),
        .high_lit  (high_lit),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_sample(sample);
            if (out_valid && !out_stall)
                board.match_word({smoothed, percent, bar_level, low_lit, mid_lit, high_lit});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        // hold the word until it is taken
        do @(posedge clk); while (in_stall);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_threshold(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_thresholds();
        for (int i = 0; i < REG_COUNT; i++)
            cfg_write(3'(i), {22'($urandom), levels[i]});
        // writes past the last register must change nothing
        cfg_write(SPARE_IDX_LO, $urandom);
        cfg_write(SPARE_IDX_HI, $urandom);
    endtask

    task automatic pick_pair(input pair_style_t style, output logic [SAMPLE_W-1:0] on_v,
                             output logic [SAMPLE_W-1:0] off_v);
        int a;
        int b;
        a = $urandom_range(0, FULL_SCALE);
        b = $urandom_range(0, FULL_SCALE);
        case (style)
            PAIR_ORDERED:
            begin
                on_v  = SAMPLE_W'((a > b) ? a : b);
                off_v = SAMPLE_W'((a > b) ? b : a);
            end
            PAIR_CROSSED:
            begin
                on_v  = SAMPLE_W'($urandom_range(0, FULL_SCALE - 1));
                off_v = SAMPLE_W'($urandom_range(on_v + 1, FULL_SCALE));
            end
            default:
            begin
                on_v  = SAMPLE_W'(a);
                off_v = SAMPLE_W'(b);
            end
        endcase
    endtask

    task automatic pick_levels(input pair_style_t style);
        pick_pair(style, levels[REG_LOW_ON], levels[REG_LOW_OFF]);
        pick_pair(style, levels[REG_MID_ON], levels[REG_MID_OFF]);
        pick_pair(style, levels[REG_HIGH_ON], levels[REG_HIGH_OFF]);
    endtask

    // hold a target level for a run so the average settles near it
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int pick;
        int v;
        if (run_left == 0)
        begin
            pick = $urandom_range(0, 9);
            target_level = (pick == 0) ? 0 :
                           (pick == 1) ? FULL_SCALE : $urandom_range(0, FULL_SCALE);
            run_left = $urandom_range(5, 40);
        end
        run_left--;
        if ($urandom_range(0, 9) == 0)
            return SAMPLE_W'($urandom_range(0, FULL_SCALE));
        v = target_level + int'($urandom_range(0, 40)) - 20;
        return (v < 0) ? '0 : (v > FULL_SCALE) ? SAMPLE_W'(FULL_SCALE) : SAMPLE_W'(v);
    endfunction

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        board = new;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start-up step to full scale, fall back to zero, then mid scale and alternating bit patterns
        repeat (WINDOW_DEF) send_sample(SAMPLE_W'(FULL_SCALE));
        repeat (7) send_sample('0);
        send_sample(10'd512);
        send_sample(10'h155);
        send_sample(10'h2AA);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 30 : (p < 4) ? 54 : 0;
            stall_pct     = (p < 2) ? 54 : (p < 4) ? 30 : 0;
            case (p)
                0: pick_levels(PAIR_ORDERED);
                1:
                begin
                    levels[REG_LOW_ON]   = '0;
                    levels[REG_LOW_OFF]  = '0;
                    levels[REG_MID_ON]   = '0;
                    levels[REG_MID_OFF]  = SAMPLE_W'(FULL_SCALE);
                    levels[REG_HIGH_ON]  = SAMPLE_W'(FULL_SCALE);
                    levels[REG_HIGH_OFF] = SAMPLE_W'(FULL_SCALE);
                end
                2: pick_levels(PAIR_CROSSED);
                4:
                begin
                    levels[REG_LOW_ON]   = LOW_ON_RST;
                    levels[REG_LOW_OFF]  = LOW_OFF_RST;
                    levels[REG_MID_ON]   = MID_ON_RST;
                    levels[REG_MID_OFF]  = MID_OFF_RST;
                    levels[REG_HIGH_ON]  = HIGH_ON_RST;
                    levels[REG_HIGH_OFF] = HIGH_OFF_RST;
                end
                default: pick_levels(PAIR_ANY);
            endcase
            load_thresholds();
            repeat (PHASE_SAMPLES) send_sample(next_sample());
            drain();
        end

        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.due_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
